@@ sv/esp_pkg.sv @@
`timescale 1ns / 1ps

package esp_pkg;

  localparam int MAX_SLOTS_DEF = 64;
  localparam logic [3:0] SLOT_BYTES = 4'd8;

  // data class codes
  localparam logic [2:0] CL_NONE        = 3'd0;
  localparam logic [2:0] CL_INTEGER     = 3'd1;
  localparam logic [2:0] CL_SSE         = 3'd2;
  localparam logic [2:0] CL_X87         = 3'd4;
  localparam logic [2:0] CL_X87UP       = 3'd5;
  localparam logic [2:0] CL_COMPLEX_X87 = 3'd6;
  localparam logic [2:0] CL_MEMORY      = 3'd7;

  typedef enum logic [2:0] {
    REQ_INIT    = 3'd0,
    REQ_PLACE   = 3'd1,
    REQ_RCLR    = 3'd2,
    REQ_RESTORE = 3'd3,
    REQ_READ    = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ARG  = 2'd1,
    ST_BOUNDS   = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // abi class merge of two classes
  function automatic logic [2:0] merge_class(input logic [2:0] a, input logic [2:0] b);
    logic [2:0] r;
    if (a == b) begin
      r = a;
    end else if (a == CL_NONE) begin
      r = b;
    end else if (b == CL_NONE) begin
      r = a;
    end else if (a == CL_MEMORY || b == CL_MEMORY) begin
      r = CL_MEMORY;
    end else if (a == CL_INTEGER || b == CL_INTEGER) begin
      r = CL_INTEGER;
    end else if (a == CL_X87 || b == CL_X87 || a == CL_X87UP || b == CL_X87UP ||
                 a == CL_COMPLEX_X87 || b == CL_COMPLEX_X87) begin
      r = CL_MEMORY;
    end else begin
      r = CL_SSE;
    end
    return r;
  endfunction

  // off mod a for a fill offset of at most 8, a nonzero
  function automatic logic [6:0] align_rem(input logic [3:0] off, input logic [6:0] a);
    logic [3:0] un;
    if (a > 7'd8) begin
      un = off;
    end else begin
      unique case (a[3:0])
        4'd1:    un = 4'd0;
        4'd2:    un = {3'b000, off[0]};
        4'd3:    un = (off >= 4'd6) ? (off - 4'd6) : ((off >= 4'd3) ? (off - 4'd3) : off);
        4'd4:    un = {2'b00, off[1:0]};
        4'd5:    un = (off >= 4'd5) ? (off - 4'd5) : off;
        4'd6:    un = (off >= 4'd6) ? (off - 4'd6) : off;
        4'd7:    un = (off >= 4'd7) ? (off - 4'd7) : off;
        4'd8:    un = {1'b0, off[2:0]};
        default: un = off;
      endcase
    end
    return {3'b000, un};
  endfunction

endpackage

@@ sv/esp_ram.sv @@
`timescale 1ns / 1ps

module esp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ sv/eightbyte_slot_packer.sv @@
`timescale 1ns / 1ps
// request flow: init, restore and rejected requests pass S_DISP, S_ORD and S_OUT; an entry read
//   adds S_ERD and S_ELD, a class range reset walks S_WALK across the slots in range, and a
//   place runs S_RD, S_ADV and S_PUT per slot touched, with S_RD2 and S_LD between S_ADV and
//   S_PUT when it has to step to a fresh slot; a step that runs off the table end goes to S_ORD
// throughput: one request at a time, the next can transfer in the cycle after the result is
//   loaded; S_OUT holds while the result register stays full; the place loop sets the pace
// reset: synchronous, clears slot classes and fills (valid bits), current slot, active slots
//   to MAX_SLOTS and the slot count register to MAX_SLOTS; no clearing pass is needed

module eightbyte_slot_packer #(
  parameter int MAX_SLOTS = esp_pkg::MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write: slots_in_use
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // from bit 0: data_class[3], data_size[10], alignment[7], entry_index[7],
  // range_count[7], pos_offset[4], zero fill
  input  logic [39:0] s_tdata,
  // from bit 0: req_type[3]
  input  logic [2:0]  s_tuser,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // from bit 0: ref_index[6], ref_offset[4], cur_index[7], cur_offset[4],
  // entry_class[3], entry_fill[4], zero fill
  output logic [31:0] m_tdata,
  // from bit 0: status[2]
  output logic [1:0]  m_tuser
);

  import esp_pkg::*;

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [10:0] MAX_W = 11'(MAX_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_RD, S_ADV, S_RD2, S_LD, S_PUT, S_WALK,
    S_ERD, S_ELD, S_ORD, S_OUT
  } state_t;

  state_t state;

  // configuration and table control
  logic [6:0] slots_in_use;
  logic [6:0] active;
  logic [6:0] cur;
  logic [MAX_SLOTS-1:0] cls_vld;
  logic [MAX_SLOTS-1:0] fil_vld;
  logic [MAX_SLOTS-1:0] restore_vld;

  // latched request
  req_t       req_r;
  logic [2:0] cls_in;
  logic [9:0] size_r;
  logic [6:0] align_r;
  logic [6:0] idx_r;
  logic [6:0] cnt_r;
  logic [3:0] pos_r;

  // work registers
  logic [6:0] wi;
  logic [6:0] wend;
  logic [3:0] off_r;
  logic [2:0] cls_r;
  logic       first;
  status_t    st;
  logic [5:0] ri;
  logic [3:0] ro;
  logic [2:0] ec;
  logic [3:0] ef;

  // slot memories
  logic [AW-1:0] addr;
  logic          cls_we, fil_we;
  logic [2:0]    cls_wdata, c_rdata;
  logic [3:0]    fil_wdata, f_rdata;
  logic          rd_cvld, rd_fvld;
  logic [2:0]    q_cls;
  logic [3:0]    q_fil;

  // place arithmetic
  logic [6:0] un;
  logic [6:0] pad;
  logic [7:0] padded;
  logic       adv;
  logic [3:0] avail;
  logic [3:0] chunk;
  logic [7:0] rsum;
  logic       restore_ok;
  logic       restore_wr;
  logic       out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  // entries never written since reset or init read as zero
  assign q_cls = rd_cvld ? c_rdata : CL_NONE;
  assign q_fil = rd_fvld ? f_rdata : 4'd0;

  always_comb begin
    unique case (state)
      S_WALK:        addr = AW'(wi);
      S_DISP, S_ERD: addr = AW'(idx_r);
      default:       addr = AW'(cur);
    endcase
  end

  // padding of the current slot to the alignment
  assign un     = align_rem(q_fil, align_r);
  assign pad    = (un != 7'd0) ? (align_r - un) : 7'd0;
  assign padded = {4'b0000, q_fil} + {1'b0, pad};
  assign adv    = (align_r == 7'd0) || (padded >= {4'b0000, SLOT_BYTES});

  assign avail = SLOT_BYTES - off_r;
  assign chunk = ({6'b000000, avail} < size_r) ? avail : size_r[3:0];

  assign rsum = {1'b0, idx_r} + {1'b0, cnt_r};

  assign restore_ok = (pos_r <= SLOT_BYTES && idx_r < active) ||
                      (pos_r == 4'd0 && idx_r == active);
  assign restore_wr = (state == S_DISP) && (req_r == REQ_RESTORE) && restore_ok &&
                      (idx_r < active);

  // every slot after the restored one drops back to empty
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (i > int'(idx_r)) begin
        restore_vld[i] = 1'b0;
      end else if (i == int'(idx_r) && restore_wr) begin
        restore_vld[i] = 1'b1;
      end else begin
        restore_vld[i] = fil_vld[i];
      end
    end
  end

  assign fil_we    = (state == S_PUT) || restore_wr;
  assign fil_wdata = (state == S_PUT) ? (off_r + chunk) : pos_r;
  assign cls_we    = (state == S_PUT) || (state == S_WALK);
  assign cls_wdata = (state == S_PUT) ? merge_class(cls_r, cls_in) : cls_in;

  esp_ram #(.WIDTH(3), .DEPTH(MAX_SLOTS), .AW(AW)) u_cls_ram (
    .clk   (clk),
    .we    (cls_we),
    .waddr (addr),
    .wdata (cls_wdata),
    .raddr (addr),
    .rdata (c_rdata)
  );

  esp_ram #(.WIDTH(4), .DEPTH(MAX_SLOTS), .AW(AW)) u_fil_ram (
    .clk   (clk),
    .we    (fil_we),
    .waddr (addr),
    .wdata (fil_wdata),
    .raddr (addr),
    .rdata (f_rdata)
  );

  always_ff @(posedge clk) begin
    // valid bits follow the registered memory read
    rd_cvld <= cls_vld[addr];
    rd_fvld <= fil_vld[addr];

    if (rst) begin
      state        <= S_IDLE;
      slots_in_use <= 7'(MAX_SLOTS);
      active       <= 7'(MAX_SLOTS);
      cur          <= 7'd0;
      cls_vld      <= '0;
      fil_vld      <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) slots_in_use <= cfg_data;

      // a new result loaded in S_OUT takes over the register
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;

      if (cls_we) cls_vld[addr] <= 1'b1;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_r   <= req_t'(s_tuser);
            cls_in  <= s_tdata[2:0];
            size_r  <= s_tdata[12:3];
            align_r <= s_tdata[19:13];
            idx_r   <= s_tdata[26:20];
            cnt_r   <= s_tdata[33:27];
            pos_r   <= s_tdata[37:34];
            st      <= ST_OK;
            ri      <= 6'd0;
            ro      <= 4'd0;
            ec      <= 3'd0;
            ef      <= 4'd0;
            first   <= 1'b1;
            state   <= S_DISP;
          end
        end

        S_DISP: begin
          unique case (req_r)
            REQ_INIT: begin
              state <= S_ORD;
              if (slots_in_use == 7'd0) begin
                st <= ST_BAD_ARG;
              end else if ({4'b0000, slots_in_use} > MAX_W) begin
                st <= ST_BOUNDS;
              end else begin
                cls_vld <= '0;
                fil_vld <= '0;
                cur     <= 7'd0;
                active  <= slots_in_use;
              end
            end
            REQ_PLACE: begin
              if (size_r == 10'd0) begin
                st    <= ST_BAD_ARG;
                state <= S_ORD;
              end else if (cur >= active) begin
                st    <= ST_OVERFLOW;
                state <= S_ORD;
              end else begin
                state <= S_RD;
              end
            end
            REQ_RCLR: begin
              if (idx_r >= active) begin
                st    <= ST_BOUNDS;
                state <= S_ORD;
              end else if (cnt_r == 7'd0) begin
                st    <= ST_BAD_ARG;
                state <= S_ORD;
              end else begin
                wi    <= idx_r;
                wend  <= (rsum > {1'b0, active}) ? active : rsum[6:0];
                state <= S_WALK;
              end
            end
            REQ_RESTORE: begin
              state <= S_ORD;
              if (!restore_ok) begin
                st <= ST_BOUNDS;
              end else begin
                fil_vld <= restore_vld;
                cur     <= idx_r;
              end
            end
            REQ_READ: begin
              if (idx_r >= active) begin
                st    <= ST_BOUNDS;
                state <= S_ORD;
              end else begin
                state <= S_ERD;
              end
            end
            default: begin
              st    <= ST_BAD_ARG;
              state <= S_ORD;
            end
          endcase
        end

        S_RD: state <= S_ADV;

        S_ADV: begin
          if (adv) begin
            // fresh slot, no padding applied to it
            cur <= cur + 7'd1;
            if ((cur + 7'd1) >= active) begin
              st    <= ST_OVERFLOW;
              state <= S_ORD;
            end else begin
              state <= S_RD2;
            end
          end else begin
            off_r <= padded[3:0];
            cls_r <= q_cls;
            state <= S_PUT;
          end
        end

        S_RD2: state <= S_LD;

        S_LD: begin
          off_r <= q_fil;
          cls_r <= q_cls;
          state <= S_PUT;
        end

        S_PUT: begin
          if (first) begin
            ri    <= cur[5:0];
            ro    <= off_r;
            first <= 1'b0;
          end
          fil_vld[addr] <= 1'b1;
          size_r  <= size_r - {6'b000000, chunk};
          align_r <= 7'd1;
          if (size_r == {6'b000000, chunk}) begin
            state <= S_ORD;
          end else begin
            state <= S_RD;
          end
        end

        S_WALK: begin
          wi <= wi + 7'd1;
          if ((wi + 7'd1) == wend) state <= S_ORD;
        end

        S_ERD: state <= S_ELD;

        S_ELD: begin
          ec    <= q_cls;
          ef    <= q_fil;
          state <= S_ORD;
        end

        S_ORD: state <= S_OUT;

        S_OUT: begin
          // hold here until the output register is free
          if (out_free) begin
            m_tvalid       <= 1'b1;
            m_tuser        <= st;
            m_tdata[5:0]   <= ri;
            m_tdata[9:6]   <= ro;
            m_tdata[16:10] <= cur;
            m_tdata[20:17] <= (cur < active) ? q_fil : 4'd0;
            m_tdata[23:21] <= ec;
            m_tdata[27:24] <= ef;
            m_tdata[31:28] <= 4'd0;
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
